// ===== hdl/spid_pkg.sv =====
// shared widths, register indexes and pipeline stage types for the speed pid
package spid_pkg;

   // field and state widths
   localparam int SPEED_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int ERR_W      = 24;
   localparam int SUM_W      = 32;
   localparam int DRIVE_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int FRAC_SHIFT = 14;
   localparam int DRIVE_TOP  = 100;
   localparam int MAG_W      = $clog2(DRIVE_TOP + 1);

   // product and raw sum widths (gains enter as signed with a zero top bit)
   localparam int PP_W  = ERR_W + GAIN_W + 1;
   localparam int PD_W  = ERR_W + 1 + GAIN_W + 1;
   localparam int PI_W  = SUM_W + GAIN_W + 1;
   localparam int RAW_W = PI_W + 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = CSR_IDX_W'(2);

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] deriv;
      logic [GAIN_W-1:0] integ;
   } gains_type;

   // error stage to multiply stage
   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic signed [ERR_W:0]   err_delta;
      logic signed [SUM_W-1:0] sum_used;
      logic                    reverse;
   } err_stage_type;

   // multiply stage to output stage
   typedef struct packed {
      logic signed [PP_W-1:0] p_term;
      logic signed [PD_W-1:0] d_term;
      logic signed [PI_W-1:0] i_term;
      logic                   reverse;
   } prod_stage_type;

endpackage

// ===== hdl/spid_chan_if.sv =====
// channel interfaces: sample input, drive result and register write port

interface spid_req_if import spid_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] target_speed;
   logic signed [SPEED_W-1:0] measured_speed;

   modport source (output valid, output target_speed, output measured_speed, input ready);
   modport sink (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface spid_rsp_if import spid_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      clamped;

   modport source (output valid, output drive, output clamped, input ready);
   modport sink (input valid, input drive, input clamped, output ready);
endinterface

interface spid_csr_if import spid_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [GAIN_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/spid_err.sv =====
// error stage: error selection, saturation and the last error / error sum state
module spid_err import spid_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [SPEED_W-1:0] target_speed,
   input  logic signed [SPEED_W-1:0] measured_speed,
   output logic                      out_valid,
   input  logic                      out_ready,
   output err_stage_type             out_stage
);

   logic signed [ERR_W-1:0] last_error_ff, last_error_in;
   logic signed [SUM_W-1:0] error_sum_ff, error_sum_in;
   logic                    out_valid_ff, out_valid_in;
   err_stage_type           out_stage_ff, out_stage_in;

   logic                    load;
   logic                    accept;
   logic signed [SPEED_W:0] diff;
   logic                    behind;
   logic signed [ERR_W:0]   err_wide;
   logic signed [ERR_W-1:0] err;
   logic signed [SUM_W-1:0] sum_used;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_next;

   // stage advances when empty or when its transaction moves on
   assign load     = !out_valid_ff || out_ready;
   assign accept   = in_valid && load;
   assign in_ready = load;

   // error: plain difference, or carried on from the last error when measured runs ahead
   always_comb begin
      diff     = (SPEED_W + 1)'(target_speed) - (SPEED_W + 1)'(measured_speed);
      behind   = diff[SPEED_W];
      err_wide = behind ? ((ERR_W + 1)'(last_error_ff) + (ERR_W + 1)'(diff))
                        : (ERR_W + 1)'(diff);
      if (err_wide[ERR_W] != err_wide[ERR_W-1]) begin
         err = err_wide[ERR_W] ? {1'b1, {(ERR_W - 1){1'b0}}} : {1'b0, {(ERR_W - 1){1'b1}}};
      end else begin
         err = err_wide[ERR_W-1:0];
      end
      sum_used = behind ? '0 : error_sum_ff;
   end

   // saturating error sum update
   always_comb begin
      sum_wide = (SUM_W + 1)'(sum_used) + (SUM_W + 1)'(err);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sum_next = sum_wide[SUM_W-1:0];
      end
   end

   // next state and stage register contents
   always_comb begin
      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      out_valid_in  = out_valid_ff;
      out_stage_in  = out_stage_ff;
      if (load) begin
         out_valid_in = in_valid;
      end
      if (accept) begin
         last_error_in          = err;
         error_sum_in           = sum_next;
         out_stage_in.err       = err;
         out_stage_in.err_delta = (ERR_W + 1)'(err) - (ERR_W + 1)'(last_error_ff);
         out_stage_in.sum_used  = sum_used;
         out_stage_in.reverse   = target_speed[SPEED_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
         out_valid_ff  <= out_valid_in;
      end
      out_stage_ff <= out_stage_in;
   end

   assign out_valid = out_valid_ff;
   assign out_stage = out_stage_ff;

   // a measured speed above target restarts the sum from the new error
   a_sum_restart : assert property (@(posedge clock) disable iff (reset)
      accept && behind |=> error_sum_ff == SUM_W'(last_error_ff))
      else $error("error sum not restarted from the carried error");

   // state moves only with an accepted transaction
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(last_error_ff) && $stable(error_sum_ff))
      else $error("pid state changed without a transaction");

   // the staged error and the stored last error agree
   a_stage_state : assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff && out_stage_ff.err == last_error_ff)
      else $error("staged error differs from stored last error");

endmodule

// ===== hdl/spid_mul.sv =====
// multiply stage: proportional, derivative and integral products
module spid_mul import spid_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  gains_type      gains,
   input  logic           in_valid,
   output logic           in_ready,
   input  err_stage_type  in_stage,
   output logic           out_valid,
   input  logic           out_ready,
   output prod_stage_type out_stage
);

   logic           out_valid_ff, out_valid_in;
   prod_stage_type out_stage_ff, out_stage_in;
   logic           load;

   assign load     = !out_valid_ff || out_ready;
   assign in_ready = load;

   // three independent products, gains taken as non-negative signed values
   always_comb begin
      out_valid_in = out_valid_ff;
      out_stage_in = out_stage_ff;
      if (load) begin
         out_valid_in = in_valid;
         out_stage_in.p_term  = in_stage.err * $signed({1'b0, gains.prop});
         out_stage_in.d_term  = in_stage.err_delta * $signed({1'b0, gains.deriv});
         out_stage_in.i_term  = in_stage.sum_used * $signed({1'b0, gains.integ});
         out_stage_in.reverse = in_stage.reverse;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_stage_ff <= out_stage_in;
   end

   assign out_valid = out_valid_ff;
   assign out_stage = out_stage_ff;

endmodule

// ===== hdl/spid_out.sv =====
// output stage: sum of terms, clamp to 0..100, reverse sign and result register
module spid_out import spid_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  prod_stage_type            in_stage,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [DRIVE_W-1:0] drive,
   output logic                      clamped
);

   localparam logic signed [RAW_W-1:0] RAW_TOP = RAW_W'(DRIVE_TOP) <<< FRAC_SHIFT;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(DRIVE_TOP);

   logic                      out_valid_ff, out_valid_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   logic                      clamped_ff, clamped_in;
   logic                      load;
   logic signed [RAW_W-1:0]   raw;
   logic                      below;
   logic                      above;
   logic [MAG_W-1:0]          mag;
   logic signed [DRIVE_W-1:0] mag_ext;

   assign load     = !out_valid_ff || out_ready;
   assign in_ready = load;

   // raw sum and clamp
   always_comb begin
      raw   = RAW_W'(in_stage.p_term) + RAW_W'(in_stage.d_term) + RAW_W'(in_stage.i_term);
      below = raw[RAW_W-1];
      above = !below && (raw > RAW_TOP);
      if (below) begin
         mag = '0;
      end else if (above) begin
         mag = MAG_W'(DRIVE_TOP);
      end else begin
         mag = raw[FRAC_SHIFT+MAG_W-1:FRAC_SHIFT];
      end
      mag_ext = DRIVE_W'(mag);
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      drive_in     = drive_ff;
      clamped_in   = clamped_ff;
      if (load) begin
         out_valid_in = in_valid;
         drive_in     = in_stage.reverse ? -mag_ext : mag_ext;
         clamped_in   = below || above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      drive_ff   <= drive_in;
      clamped_ff <= clamped_in;
   end

   assign out_valid = out_valid_ff;
   assign drive     = drive_ff;
   assign clamped   = clamped_ff;

   // drive stays within the percent range
   a_drive_range : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> drive_ff <= DRIVE_MAX && drive_ff >= -DRIVE_MAX)
      else $error("drive outside percent range");

   // a clamped result sits on one of the range ends
   a_clamp_ends : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && clamped_ff |->
         drive_ff == '0 || drive_ff == DRIVE_MAX || drive_ff == -DRIVE_MAX)
      else $error("clamped drive not at a range end");

endmodule

// ===== hdl/speed_pid_one_sided_clamp_top.sv =====
// top level of the speed pid with one-sided output clamp
//
// Speed PID controller: each req transaction carries a target and a measured speed
// (signed Q8.8) and yields one rsp transaction with a drive percent of -100..100 and a
// clamp flag. A new sample is taken every clock cycle while the rsp side does not hold
// the pipeline. A sample passes three registers (error stage, multiply stage, output
// register) before its result is presented on rsp. A stalled rsp side only holds the
// pipeline once all three stages are full. The rate is set by the error stage, where
// the last error and the error sum are updated in the cycle a sample is accepted so
// the next sample can use them at once. Gains are unsigned Q10.6, written through the
// csr port (index 0 proportional, 1 derivative, 2 integral, index 3 ignored); the user
// must write them only while no sample is in flight, which the block does not enforce.
// All gains reset to zero.
module speed_pid_one_sided_clamp_top import spid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   spid_req_if.sink    req_chan,
   spid_rsp_if.source  rsp_chan,
   spid_csr_if.sink    csr_chan
);

   gains_type      gains_ff, gains_in;
   logic           err_valid;
   logic           err_ready;
   err_stage_type  err_stage;
   logic           mul_valid;
   logic           mul_ready;
   prod_stage_type mul_stage;

   // gain registers, always ready for a write transaction
   assign csr_chan.ready = 1'b1;

   always_comb begin
      gains_in = gains_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_PROP_GAIN:  gains_in.prop  = csr_chan.data;
            CSR_DERIV_GAIN: gains_in.deriv = csr_chan.data;
            CSR_INTEG_GAIN: gains_in.integ = csr_chan.data;
            default:        gains_in       = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // error stage
   spid_err u_err (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .target_speed   (req_chan.target_speed),
      .measured_speed (req_chan.measured_speed),
      .out_valid      (err_valid),
      .out_ready      (err_ready),
      .out_stage      (err_stage)
   );

   // multiply stage
   spid_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains_ff),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .in_stage  (err_stage),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_stage (mul_stage)
   );

   // clamp and result register
   spid_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_stage  (mul_stage),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .drive     (rsp_chan.drive),
      .clamped   (rsp_chan.clamped)
   );

endmodule

// ===== test/tb_speed_pid_one_sided_clamp_top.sv =====
// testbench for the speed pid with one-sided clamp: predicted drive checked per transaction
module tb_speed_pid_one_sided_clamp_top import spid_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_CAP  = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);
   localparam longint ERR_HI = (64'sd1 <<< (ERR_W - 1)) - 1;
   localparam longint ERR_LO = -(64'sd1 <<< (ERR_W - 1));
   localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LO = -(64'sd1 <<< (SUM_W - 1));

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      clamped;
   } drive_result_type;

   logic clock;
   logic reset;

   spid_req_if req_chan ();
   spid_rsp_if rsp_chan ();
   spid_csr_if csr_chan ();

   speed_pid_one_sided_clamp_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // predictor state and configuration
   gains_type               gains;
   logic signed [ERR_W-1:0] last_err;
   logic signed [SUM_W-1:0] err_sum;
   drive_result_type        pending_drives [$];

   int  mismatch_count;
   int  cycle_count;
   int  stall_left;
   bit  idle_on;
   drive_result_type got_drive;
   drive_result_type want_drive;

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic longint clip_to(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic signed [SPEED_W-1:0] to_speed(input int v);
      return SPEED_W'(clip_to(v, -32768, 32767));
   endfunction

   // drive prediction for one accepted sample
   function automatic void predict_drive(input logic signed [SPEED_W-1:0] tgt,
                                         input logic signed [SPEED_W-1:0] meas);
      longint diff;
      longint err;
      longint prev;
      longint sum_used;
      longint raw;
      drive_result_type res;
      diff = longint'(tgt) - longint'(meas);
      prev = last_err;
      sum_used = err_sum;
      if (tgt >= meas) begin
         err = clip_to(diff, ERR_LO, ERR_HI);
      end else begin
         // overshoot: error carries the previous one, sum starts over
         err = clip_to(prev + diff, ERR_LO, ERR_HI);
         sum_used = 0;
      end
      raw = err * longint'(gains.prop) + (err - prev) * longint'(gains.deriv)
            + sum_used * longint'(gains.integ);
      err_sum = SUM_W'(clip_to(sum_used + err, SUM_LO, SUM_HI));
      last_err = ERR_W'(err);
      res.clamped = 1'b0;
      if (raw < 0) begin
         res.drive = '0;
         res.clamped = 1'b1;
      end else if (raw > (longint'(DRIVE_TOP) <<< FRAC_SHIFT)) begin
         res.drive = DRIVE_W'(DRIVE_TOP);
         res.clamped = 1'b1;
      end else begin
         res.drive = DRIVE_W'(raw >>> FRAC_SHIFT);
      end
      if (tgt[SPEED_W-1]) res.drive = -res.drive;
      pending_drives.push_back(res);
   endfunction

   function automatic void report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endfunction

   // result checking at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_drive.drive = rsp_chan.drive;
         got_drive.clamped = rsp_chan.clamped;
         if (pending_drives.size() == 0) begin
            report_mismatch("unexpected transaction drive", 0, got_drive.drive);
         end else begin
            want_drive = pending_drives.pop_front();
            if (got_drive.drive !== want_drive.drive)
               report_mismatch("drive", want_drive.drive, got_drive.drive);
            if (got_drive.clamped !== want_drive.clamped)
               report_mismatch("clamped", want_drive.clamped, got_drive.clamped);
         end
      end
   end

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready = 1'b1;
         if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
      end
   end

   // send one sample transaction, with an optional idle burst ahead of it
   task automatic send_sample(input logic signed [SPEED_W-1:0] tgt,
                              input logic signed [SPEED_W-1:0] meas);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.target_speed = tgt;
      req_chan.measured_speed = meas;
      do @(posedge clock); while (!req_chan.ready);
      predict_drive(tgt, meas);
   endtask

   // stop sending and let every expected result come back
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_gain(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data = val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_PROP_GAIN: begin
            gains.prop = val;
         end
         CSR_DERIV_GAIN: begin
            gains.deriv = val;
         end
         CSR_INTEG_GAIN: begin
            gains.integ = val;
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                              input logic [GAIN_W-1:0] ki);
      wait_idle();
      write_gain(CSR_PROP_GAIN, kp);
      write_gain(CSR_DERIV_GAIN, kd);
      write_gain(CSR_INTEG_GAIN, ki);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return GAIN_W'($urandom_range(0, 200));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   // gains at reset are zero: drive stays 0 and nothing clamps
   task automatic test_reset_gains();
      send_sample(16'sh7FFF, -16'sh8000);
      send_sample(-16'sh8000, 16'sh7FFF);
   endtask

   // proportional only, around the 0 and 100.0 edges
   task automatic test_clamp_edges();
      write_gains(GAIN_W'(64), '0, '0);
      send_sample(to_speed(25600), 16'sh0000);
      send_sample(to_speed(25601), 16'sh0000);
      send_sample(-16'sh0001, to_speed(-25601));
      send_sample(16'sh0000, 16'sh0000);
      send_sample(16'sh0000, to_speed(256));
      send_sample(to_speed(-256), 16'sh0000);
      send_sample(-16'sh0001, -16'sh0001);
   endtask

   // derivative and integral paths alone, then every gain at its maximum
   task automatic test_gain_terms();
      write_gains('0, GAIN_W'(64), '0);
      send_sample(to_speed(1000), 16'sh0000);
      send_sample(to_speed(3000), 16'sh0000);
      send_sample(to_speed(2000), 16'sh0000);
      write_gains('0, '0, GAIN_W'(64));
      send_sample(to_speed(256), 16'sh0000);
      send_sample(to_speed(256), 16'sh0000);
      send_sample(to_speed(256), 16'sh0000);
      write_gains('1, '1, '1);
      send_sample(16'sh7FFF, -16'sh8000);
      send_sample(16'sh0001, 16'sh0000);
      send_sample(16'sh0000, 16'sh0000);
   endtask

   // a write to the spare index leaves the gains alone
   task automatic test_unused_index();
      write_gains(GAIN_W'(32), GAIN_W'(16), GAIN_W'(1));
      write_gain(CSR_UNUSED, '1);
      send_sample(to_speed(256), 16'sh0000);
      send_sample(16'sh0000, 16'sh0000);
   endtask

   // sustained overshoot drives the error to its negative limit
   task automatic test_error_saturation();
      int i;
      write_gains(GAIN_W'(1), GAIN_W'(1), GAIN_W'(1));
      for (i = 0; i < 140; i++) send_sample(-16'sh8000, 16'sh7FFF);
      send_sample(16'sh0000, 16'sh0001);
   endtask

   // long run at full positive error builds a large sum on the integral path
   task automatic test_sum_growth();
      int i;
      write_gains('0, '0, GAIN_W'(1));
      for (i = 0; i < 200; i++) send_sample(16'sh7FFF, -16'sh8000);
      send_sample(16'sh0000, 16'sh0001);
   endtask

   // control-like traffic: tracking, overshoot, runaway and noise
   task automatic run_control_traffic(input int count);
      int sent;
      int kind;
      int len;
      int base;
      int offs;
      int i;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         base = $urandom_range(0, 16000) - 8000;
         if (kind < 5) begin
            // measured closes in on target, sometimes passing it
            len = $urandom_range(4, 16);
            offs = $urandom_range(0, 4000);
            for (i = 0; i < len; i++) begin
               send_sample(to_speed(base), to_speed(base - offs));
               offs = offs / 2 - ($urandom_range(0, 1) ? $urandom_range(0, 50) : 0);
            end
         end else if (kind < 7) begin
            len = $urandom_range(2, 8);
            for (i = 0; i < len; i++)
               send_sample(to_speed(base), to_speed(base + $urandom_range(1, 3000)));
         end else if (kind == 7) begin
            len = $urandom_range(5, 40);
            for (i = 0; i < len; i++)
               send_sample(to_speed(-32768 + $urandom_range(0, 500)),
                           to_speed(32767 - $urandom_range(0, 500)));
         end else begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
               send_sample(SPEED_W'($urandom), SPEED_W'($urandom));
         end
         sent += len;
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 6; phase++) begin
         write_gains(pick_gain(), pick_gain(), pick_gain());
         // the last phase runs without idling on either side
         idle_on = (phase != 5);
         run_control_traffic(240);
      end
   endtask

   // sequence of tests
   initial begin
      reset = 1'b1;
      idle_on = 1'b1;
      stall_left = 0;
      mismatch_count = 0;
      cycle_count = 0;
      gains = '0;
      last_err = '0;
      err_sum = '0;
      req_chan.valid = 1'b0;
      req_chan.target_speed = '0;
      req_chan.measured_speed = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_gains();
      test_clamp_edges();
      test_gain_terms();
      test_unused_index();
      test_error_saturation();
      test_sum_growth();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== speed_pid_one_sided_clamp_top.f =====
hdl/spid_pkg.sv
hdl/spid_chan_if.sv
hdl/spid_err.sv
hdl/spid_mul.sv
hdl/spid_out.sv
hdl/speed_pid_one_sided_clamp_top.sv
test/tb_speed_pid_one_sided_clamp_top.sv
